/* rtl/core/psue_pkg.sv */
// Package: constants, payload types and state encodings for the swarm engine.
package psue_pkg;

    localparam int PARTICLES = 32;
    localparam int DIMS      = 8;
    localparam int PW        = $clog2(PARTICLES);
    localparam int DW        = $clog2(DIMS);
    localparam int EW        = PW + DW;
    localparam int ELEMS     = PARTICLES * DIMS;
    localparam int QDEPTH    = 2;

    localparam logic signed [31:0] SCORE_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [2:0] {
        MODE_LOAD  = 3'd0,
        MODE_INIT  = 3'd1,
        MODE_COEF  = 3'd2,
        MODE_SCORE = 3'd3,
        MODE_GBEST = 3'd4,
        MODE_MOVE  = 3'd5,
        MODE_READ  = 3'd6,
        MODE_SPARE = 3'd7
    } mode_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic [4:0]         particle;
        logic [2:0]         dim;
        logic signed [31:0] position_in;
        logic signed [31:0] velocity_in;
        logic signed [15:0] coef_inertia;
        logic signed [15:0] coef_cognitive;
        logic signed [15:0] coef_social;
        logic signed [31:0] score;
        logic [15:0]        rand_one;
        logic [15:0]        rand_two;
    } in_word_t;

    typedef struct packed {
        logic               improved;
        logic signed [31:0] position_out;
        logic signed [31:0] velocity_out;
        logic signed [31:0] best_position_out;
        logic signed [31:0] global_position_out;
        logic signed [31:0] best_score_out;
        logic signed [31:0] global_score_out;
        logic [4:0]         global_particle_out;
    } out_word_t;

    // Classified command handed from front to back.
    typedef struct packed {
        mode_t              mode;
        logic               pok;
        logic               dok;
        logic [PW-1:0]      p;
        logic [DW-1:0]      d;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [15:0] cw;
        logic signed [15:0] c1;
        logic signed [15:0] c2;
        logic signed [31:0] score;
        logic [15:0]        r1;
        logic [15:0]        r2;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_EXEC,
        ST_COPY,
        ST_SCAN,
        ST_SCAN_CMP,
        ST_GCOPY,
        ST_MUL,
        ST_MUL2,
        ST_SUM,
        ST_WB,
        ST_FETCH,
        ST_OUT,
        ST_CLEAR
    } state_t;

endpackage

/* rtl/core/psue_ram.sv */
// Generic single-port RAM with registered read.
module psue_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write the addressed word; the read returns its contents before the write.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/core/psue_front.sv */
// Front end: accepts input words, classifies them, and queues commands.
module psue_front
    import psue_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_word_t in_word,
    input  logic     in_valid,
    output logic     in_stall,
    output cmd_t     cmd,
    output logic     cmd_valid,
    input  logic     cmd_take
);

    cmd_t       q_reg [QDEPTH];
    logic [0:0] wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;
    cmd_t       c;

    assign in_stall  = (cnt_reg == 2'(QDEPTH));
    assign push      = in_valid && !in_stall;
    assign pop       = cmd_take && cmd_valid;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];

    // Classify the incoming word.
    always_comb
    begin
        c.mode  = mode_t'(in_word.mode);
        c.pok   = ({27'd0, in_word.particle} < 32'(PARTICLES));
        c.dok   = ({29'd0, in_word.dim} < 32'(DIMS));
        c.p     = in_word.particle[PW-1:0];
        c.d     = in_word.dim[DW-1:0];
        c.pos   = in_word.position_in;
        c.vel   = in_word.velocity_in;
        c.cw    = in_word.coef_inertia;
        c.c1    = in_word.coef_cognitive;
        c.c2    = in_word.coef_social;
        c.score = in_word.score;
        c.r1    = in_word.rand_one;
        c.r2    = in_word.rand_two;
    end

    // Store the command.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= c;
        end
    end

    // Advance queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* rtl/core/psue_back.sv */
// Back end: executes commands on the swarm tables and produces result words.
module psue_back
    import psue_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  logic      cmd_valid,
    output logic      cmd_take,
    output out_word_t out_word,
    output logic      out_valid,
    input  logic      out_stall
);

    state_t state_reg, state_next;
    cmd_t   c_reg, c_next;

    // Tables in RAM: position, velocity, personal best.
    logic          x_we, v_we, b_we;
    logic [EW-1:0] x_addr, b_addr;
    logic [31:0]   x_wd, v_wd, b_wd, x_rd, v_rd, b_rd;

    psue_ram #(.WIDTH(32), .DEPTH(ELEMS)) u_xram
        (.clk(clk), .we(x_we), .addr(x_addr), .wdata(x_wd), .rdata(x_rd));
    psue_ram #(.WIDTH(32), .DEPTH(ELEMS)) u_vram
        (.clk(clk), .we(v_we), .addr(x_addr), .wdata(v_wd), .rdata(v_rd));
    psue_ram #(.WIDTH(32), .DEPTH(ELEMS)) u_bram
        (.clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wd), .rdata(b_rd));

    // RAM read data; the tables are zeroed by the clearing pass after reset.
    logic [EW-1:0]      clr_reg, clr_next;
    logic signed [31:0] x_q, v_q, b_q;
    assign x_q = x_rd;
    assign v_q = v_rd;
    assign b_q = b_rd;

    // Small register tables.
    logic signed [31:0] pscore_reg [PARTICLES];
    logic signed [15:0] w_reg [DIMS];
    logic signed [15:0] c1_reg [DIMS];
    logic signed [15:0] c2_reg [DIMS];
    logic signed [31:0] grow_reg [DIMS];
    logic signed [31:0] gscore_reg;
    logic [PW-1:0]      gidx_reg;

    // Sequencing counters and arithmetic registers.
    logic [PW:0]        pi_reg, pi_next;
    logic [DW:0]        k_reg, k_next;
    logic               imp_reg, imp_next;
    logic [PW-1:0]      win_reg, win_next;
    logic signed [31:0] best_reg, best_next;
    logic               won_reg, won_next;
    logic signed [32:0] d1_reg, d2_reg;
    logic signed [32:0] cr1_reg, cr2_reg;
    logic signed [63:0] t0_reg, t1_reg, t2_reg;
    logic signed [31:0] nv_reg;
    logic signed [31:0] xs_reg;
    out_word_t          o_reg, o_next;
    logic               ov_reg, ov_next;

    logic [EW-1:0] e_addr;
    assign e_addr = {c_reg.p, c_reg.d};

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sh0_7FFF_FFFF)
        begin
            return 32'sh7FFF_FFFF;
        end
        else if (v < -38'sh0_8000_0000)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [35:0] rnd(input logic signed [63:0] v,
                                                input logic [5:0] s);
        logic signed [63:0] t;
        t = (v + (64'sd1 <<< (s - 6'd1))) >>> s;
        return t[35:0];
    endfunction

    assign out_word  = o_reg;
    assign out_valid = ov_reg;
    assign cmd_take  = (state_reg == ST_IDLE) && !ov_reg;

    // Next state, RAM controls and result.
    always_comb
    begin
        state_next = state_reg;
        c_next     = c_reg;
        clr_next   = clr_reg;
        pi_next    = pi_reg;
        k_next     = k_reg;
        imp_next   = imp_reg;
        win_next   = win_reg;
        best_next  = best_reg;
        won_next   = won_reg;
        o_next     = o_reg;
        ov_next    = ov_reg && out_stall;
        x_we = 1'b0; v_we = 1'b0; b_we = 1'b0;
        x_addr = e_addr; b_addr = e_addr;
        x_wd = c_reg.pos; v_wd = c_reg.vel; b_wd = c_reg.pos;
        case (state_reg)
            ST_CLEAR:
            begin
                // Zero one element of every table per cycle.
                x_addr = clr_reg; b_addr = clr_reg;
                x_we = 1'b1; v_we = 1'b1; b_we = 1'b1;
                x_wd = '0; v_wd = '0; b_wd = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == EW'(ELEMS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid && !ov_reg)
                begin
                    c_next     = cmd;
                    imp_next   = 1'b0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FETCH;
                case (c_reg.mode)
                    MODE_LOAD:
                    begin
                        x_we = c_reg.pok && c_reg.dok;
                        v_we = x_we;
                    end
                    MODE_INIT:
                    begin
                        x_we = c_reg.pok && c_reg.dok;
                        b_we = x_we;
                    end
                    MODE_SCORE:
                    begin
                        if (c_reg.pok && c_reg.score < pscore_reg[c_reg.p])
                        begin
                            imp_next   = 1'b1;
                            k_next     = '0;
                            state_next = ST_RD;
                        end
                    end
                    MODE_GBEST:
                    begin
                        pi_next    = '0;
                        best_next  = gscore_reg;
                        won_next   = 1'b0;
                        win_next   = gidx_reg;
                        state_next = ST_SCAN;
                    end
                    MODE_MOVE:
                    begin
                        if (c_reg.pok && c_reg.dok)
                        begin
                            state_next = ST_RD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_RD:
            begin
                // Read position row element k (score) or the element (move).
                if (c_reg.mode == MODE_SCORE)
                begin
                    x_addr     = {c_reg.p, k_reg[DW-1:0]};
                    state_next = ST_COPY;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_COPY:
            begin
                b_addr = {c_reg.p, k_reg[DW-1:0]};
                b_we   = 1'b1;
                b_wd   = x_q;
                if (k_reg == (DW+1)'(DIMS - 1))
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_SCAN:
            begin
                if (pscore_reg[pi_reg[PW-1:0]] < best_reg)
                begin
                    best_next = pscore_reg[pi_reg[PW-1:0]];
                    win_next  = pi_reg[PW-1:0];
                    won_next  = 1'b1;
                end
                if (pi_reg == (PW+1)'(PARTICLES - 1))
                begin
                    k_next     = '0;
                    state_next = won_next ? ST_SCAN_CMP : ST_FETCH;
                end
                else
                begin
                    pi_next = pi_reg + 1'b1;
                end
            end
            ST_SCAN_CMP:
            begin
                b_addr     = {win_reg, k_reg[DW-1:0]};
                imp_next   = 1'b1;
                state_next = ST_GCOPY;
            end
            ST_GCOPY:
            begin
                b_addr = {win_reg, k_reg[DW-1:0]};
                if (k_reg == (DW+1)'(DIMS - 1))
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_MUL:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                // Write back the new velocity and the saturated position sum.
                x_we = 1'b1; v_we = 1'b1;
                x_wd = sat32(38'(xs_reg) + 38'(nv_reg));
                v_wd = nv_reg;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                o_next.improved            = imp_reg;
                o_next.position_out        = (c_reg.pok && c_reg.dok) ? x_q : '0;
                o_next.velocity_out        = (c_reg.pok && c_reg.dok) ? v_q : '0;
                o_next.best_position_out   = (c_reg.pok && c_reg.dok) ? b_q : '0;
                o_next.global_position_out = c_reg.dok ? grow_reg[c_reg.d] : '0;
                o_next.best_score_out      = c_reg.pok ? pscore_reg[c_reg.p] : '0;
                o_next.global_score_out    = gscore_reg;
                o_next.global_particle_out = 5'(gidx_reg);
                ov_next                    = 1'b1;
                state_next                 = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
            gscore_reg <= SCORE_MAX;
            gidx_reg  <= '0;
            for (int i = 0; i < PARTICLES; i++)
            begin
                pscore_reg[i] <= SCORE_MAX;
            end
            for (int i = 0; i < DIMS; i++)
            begin
                w_reg[i]    <= '0;
                c1_reg[i]   <= '0;
                c2_reg[i]   <= '0;
                grow_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            if (state_reg == ST_EXEC && c_reg.mode == MODE_COEF && c_reg.dok)
            begin
                w_reg[c_reg.d]  <= c_reg.cw;
                c1_reg[c_reg.d] <= c_reg.c1;
                c2_reg[c_reg.d] <= c_reg.c2;
            end
            if (state_reg == ST_EXEC && c_reg.mode == MODE_SCORE && c_reg.pok
                && c_reg.score < pscore_reg[c_reg.p])
            begin
                pscore_reg[c_reg.p] <= c_reg.score;
            end
            if (state_reg == ST_GCOPY)
            begin
                grow_reg[k_reg[DW-1:0]] <= b_q;
            end
            if (state_reg == ST_SCAN && pi_reg == (PW+1)'(PARTICLES - 1) && won_next)
            begin
                gscore_reg <= best_next;
                gidx_reg   <= win_next;
            end
        end
    end

    // Payload and arithmetic registers.
    always_ff @(posedge clk)
    begin
        c_reg    <= c_next;
        pi_reg   <= pi_next;
        k_reg    <= k_next;
        imp_reg  <= imp_next;
        win_reg  <= win_next;
        best_reg <= best_next;
        won_reg  <= won_next;
        o_reg    <= o_next;
        // Differences, coefficient-random products and the inertia product.
        if (state_reg == ST_MUL)
        begin
            d1_reg  <= 33'(b_q) - 33'(x_q);
            d2_reg  <= 33'(grow_reg[c_reg.d]) - 33'(x_q);
            cr1_reg <= 33'(c1_reg[c_reg.d] * $signed({1'b0, c_reg.r1}));
            cr2_reg <= 33'(c2_reg[c_reg.d] * $signed({1'b0, c_reg.r2}));
            t0_reg  <= 64'(w_reg[c_reg.d] * v_q);
            xs_reg  <= x_q;
        end
        // Attraction terms.
        if (state_reg == ST_MUL2)
        begin
            t1_reg <= 64'(cr1_reg * d1_reg);
            t2_reg <= 64'(cr2_reg * d2_reg);
        end
        // Round, add and saturate.
        if (state_reg == ST_SUM)
        begin
            nv_reg <= sat32(38'(rnd(t0_reg, 6'd12)) + 38'(rnd(t1_reg, 6'd28))
                            + 38'(rnd(t2_reg, 6'd28)));
        end
    end

endmodule

/* rtl/core/particle_swarm_update_engine.sv */
// Particle swarm update engine: front queue plus back execution unit.
// Throughput: one word at a time in the back end, set by its sequencer;
// a two-entry queue lets the front accept while the back works.
// Reset: asynchronous active low; scores reset to maximum, then a clearing
// pass over all ELEMS (256) elements zeroes the element tables before the
// back end takes the first word.
module particle_swarm_update_engine
    import psue_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_word_t  in_word,
    input  logic      in_valid,
    output logic      in_stall,
    output out_word_t out_word,
    output logic      out_valid,
    input  logic      out_stall
);

    cmd_t cmd;
    logic cmd_valid, cmd_take;

    psue_front u_front (
        .clk(clk), .rst_n(rst_n), .in_word(in_word), .in_valid(in_valid),
        .in_stall(in_stall), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
    );

    psue_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid),
        .cmd_take(cmd_take), .out_word(out_word), .out_valid(out_valid),
        .out_stall(out_stall)
    );

endmodule
